>>> src/speed_ramp_generator_assert.svh
`ifndef SPEED_RAMP_GENERATOR_ASSERT_SVH
`define SPEED_RAMP_GENERATOR_ASSERT_SVH

// check a consequence in the same cycle
`define SRG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("speed_ramp_generator: same-cycle check failed");

// check a consequence in the next cycle
`define SRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("speed_ramp_generator: next-cycle check failed");

`endif

>>> src/srg_pkg.sv
package srg_pkg;

  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned RAMP_W    = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PERIOD_W  = 9;
  localparam int unsigned STEP_W    = RATE_W + PERIOD_W;

  localparam logic [PERIOD_W-1:0] CONTROL_PERIOD_Q16 = PERIOD_W'(328);

  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DECEL_RATE = CFG_IDX_W'(1);

  localparam logic [RATE_W-1:0] ACCEL_RESET = RATE_W'(200);
  localparam logic [RATE_W-1:0] DECEL_RESET = RATE_W'(1000);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_SNAP     = 2'd1,
    CMD_SET_BOTH = 2'd2,
    CMD_SET_RAMP = 2'd3
  } cmd_t;

  function automatic logic signed [SPEED_W-1:0] q16_whole(input logic signed [RAMP_W-1:0] q);
    logic signed [SPEED_W-1:0] fl;
    fl = q[RAMP_W-1:16];
    if (q[RAMP_W-1] && (q[15:0] != 16'd0)) begin
      fl = fl + SPEED_W'(1);
    end
    return fl;
  endfunction

endpackage

>>> src/speed_ramp_generator.sv
// An accepted item is held in the input stage registers; its result is registered into
// the output stage (out_valid high after it), later only while a waiting result holds it.
// Throughput: one item per cycle while out_ready is high; the input stalls only when
// both stages hold items and the result waits.
// Compares, a 16x9 multiply, an add and a clamp sit between the input and state registers.
// Reset (rst_n low, synchronous): target, ramp and drive speed clear to zero,
// accel_rate returns to 200, decel_rate to 1000, both pipeline stages empty.
module speed_ramp_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [srg_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [srg_pkg::SPEED_W-1:0]   in_speed_value,
  input  logic signed [srg_pkg::SPEED_W-1:0]   in_left_wheel_speed,
  input  logic signed [srg_pkg::SPEED_W-1:0]   in_right_wheel_speed,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [srg_pkg::SPEED_W-1:0]   out_drive_speed,
  output logic signed [srg_pkg::SPEED_W-1:0]   out_ramp_whole,
  output logic signed [srg_pkg::SPEED_W-1:0]   out_target_now,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [srg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [srg_pkg::RATE_W-1:0]           cfg_data
);
  import srg_pkg::*;

  `include "speed_ramp_generator_assert.svh"

  logic                        s1_valid_r;
  cmd_t                        cmd_r;
  logic signed [SPEED_W-1:0]   speed_r;
  logic signed [SPEED_W-1:0]   left_r;
  logic signed [SPEED_W-1:0]   right_r;
  logic                        out_valid_r;

  logic [RATE_W-1:0]           accel_r;
  logic [RATE_W-1:0]           decel_r;
  logic signed [SPEED_W-1:0]   target_r;
  logic signed [RAMP_W-1:0]    ramp_r;
  logic signed [SPEED_W-1:0]   drive_r;
  logic signed [SPEED_W-1:0]   ramp_whole_r;

  logic signed [SPEED_W-1:0]   target_nxt;
  logic signed [RAMP_W-1:0]    ramp_nxt;
  logic signed [SPEED_W-1:0]   drive_nxt;

  logic                        advance;
  logic signed [RAMP_W-1:0]    tq;
  logic signed [RAMP_W-1:0]    vq;
  logic [STEP_W-1:0]           step_up;
  logic [STEP_W-1:0]           step_dn;
  logic signed [RAMP_W+1:0]    ramp_x;
  logic signed [RAMP_W+1:0]    tq_x;
  logic signed [RAMP_W+1:0]    ramp_up;
  logic signed [RAMP_W+1:0]    ramp_dn;
  logic signed [RAMP_W-1:0]    ramp_tick;

  logic signed [SPEED_W:0]     wheel_sum;
  logic signed [SPEED_W-1:0]   measured;
  logic signed [RAMP_W:0]      diff_q;
  logic signed [SPEED_W+1:0]   dc;
  logic signed [SPEED_W+1:0]   dm;
  logic signed [SPEED_W+1:0]   ac;
  logic signed [SPEED_W+1:0]   am;
  logic signed [RAMP_W-1:0]    ramp_snap;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_drive_speed = drive_r;
  assign out_ramp_whole  = ramp_whole_r;
  assign out_target_now  = target_r;

  assign tq = {target_r, 16'h0000};
  assign vq = {speed_r, 16'h0000};

  // tick: step toward the target, clamp at it
  always_comb begin
    step_up   = {{PERIOD_W{1'b0}}, accel_r} * {{RATE_W{1'b0}}, CONTROL_PERIOD_Q16};
    step_dn   = {{PERIOD_W{1'b0}}, decel_r} * {{RATE_W{1'b0}}, CONTROL_PERIOD_Q16};
    ramp_x    = {{2{ramp_r[RAMP_W-1]}}, ramp_r};
    tq_x      = {{2{tq[RAMP_W-1]}}, tq};
    ramp_up   = ramp_x + $signed({{(RAMP_W+2-STEP_W){1'b0}}, step_up});
    ramp_dn   = ramp_x - $signed({{(RAMP_W+2-STEP_W){1'b0}}, step_dn});
    ramp_tick = ramp_r;
    if (tq > ramp_r) begin
      ramp_tick = (ramp_up > tq_x) ? tq : ramp_up[RAMP_W-1:0];
    end else if (tq < ramp_r) begin
      ramp_tick = (ramp_dn < tq_x) ? tq : ramp_dn[RAMP_W-1:0];
    end
  end

  // snap rule
  always_comb begin
    wheel_sum = {left_r[SPEED_W-1], left_r} + {right_r[SPEED_W-1], right_r};
    measured  = wheel_sum[SPEED_W:1];
    if (wheel_sum[SPEED_W] && wheel_sum[0]) begin
      measured = measured + SPEED_W'(1);
    end
    diff_q = {vq[RAMP_W-1], vq} - {ramp_r[RAMP_W-1], ramp_r};
    dc     = {diff_q[RAMP_W], diff_q[RAMP_W:16]};
    if (diff_q[RAMP_W] && (diff_q[15:0] != 16'd0)) begin
      dc = dc + (SPEED_W+2)'(1);
    end
    dm = {{2{speed_r[SPEED_W-1]}}, speed_r} - {{2{measured[SPEED_W-1]}}, measured};
    ac = dc[SPEED_W+1] ? -dc : dc;
    am = dm[SPEED_W+1] ? -dm : dm;
    ramp_snap = ramp_r;
    if (dc[SPEED_W+1] == dm[SPEED_W+1]) begin
      if (ac > am) begin
        ramp_snap = {measured, 16'h0000};
      end
    end else begin
      ramp_snap = vq;
    end
  end

  always_comb begin
    target_nxt = target_r;
    ramp_nxt   = ramp_r;
    drive_nxt  = drive_r;
    unique case (cmd_r)
      CMD_TICK: begin
        ramp_nxt  = ramp_tick;
        drive_nxt = q16_whole(ramp_tick);
      end
      CMD_SNAP: begin
        target_nxt = speed_r;
        ramp_nxt   = ramp_snap;
      end
      CMD_SET_BOTH: begin
        target_nxt = speed_r;
        ramp_nxt   = vq;
      end
      CMD_SET_RAMP: begin
        ramp_nxt = vq;
      end
      default: begin
        ramp_nxt = ramp_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r   <= cmd_t'(in_cmd);
      speed_r <= in_speed_value;
      left_r  <= in_left_wheel_speed;
      right_r <= in_right_wheel_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      target_r     <= '0;
      ramp_r       <= '0;
      drive_r      <= '0;
      ramp_whole_r <= '0;
    end else begin
      if (advance) begin
        out_valid_r  <= 1'b1;
        target_r     <= target_nxt;
        ramp_r       <= ramp_nxt;
        drive_r      <= drive_nxt;
        ramp_whole_r <= q16_whole(ramp_nxt);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= ACCEL_RESET;
      decel_r <= DECEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_ACCEL_RATE) begin
        accel_r <= cfg_data;
      end else if (cfg_index == CFG_DECEL_RATE) begin
        decel_r <= cfg_data;
      end
    end
  end

  `SRG_ASSERT_NOW(a_ready_stall, !in_ready, s1_valid_r && out_valid_r && !out_ready)
  `SRG_ASSERT_NEXT(a_drive_only_tick, advance && (cmd_r != CMD_TICK), drive_r == $past(drive_r))
  `SRG_ASSERT_NEXT(a_tick_no_overshoot_dn, advance && (cmd_r == CMD_TICK) && (tq <= ramp_r),
                   ramp_r >= $past(tq))
  `SRG_ASSERT_NEXT(a_tick_no_overshoot_up, advance && (cmd_r == CMD_TICK) && (tq >= ramp_r),
                   ramp_r <= $past(tq))

endmodule
